// ===== sv/http2_frame_header_parser_defines.svh =====
// assertion macros shared by the http2 frame header parser rtl
`ifndef HTTP2_FRAME_HEADER_PARSER_DEFINES_SVH
`define HTTP2_FRAME_HEADER_PARSER_DEFINES_SVH

// checked only while out of reset
`define H2FP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define H2FP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/h2fp_pkg.sv =====
// shared types and constants of the http2 frame header parser
`default_nettype none

package h2fp_pkg;

    localparam int HDR_BYTES = 9;
    localparam logic [3:0] HDR_LAST      = 4'(HDR_BYTES - 1);
    localparam logic [3:0] HDR_TYPE_POS  = 4'd3;
    localparam logic [3:0] HDR_FLAGS_POS = 4'd4;

    localparam logic [7:0]  FRAME_TYPE_GOAWAY = 8'd7;
    localparam logic [7:0]  KNOWN_TYPES       = 8'd10;
    localparam logic [23:0] GOAWAY_MIN_LEN    = 24'd8;
    localparam logic [3:0]  GOAWAY_BYTES      = 4'd8;
    localparam logic [3:0]  GOAWAY_LAST       = GOAWAY_BYTES - 4'd1;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_GOAWAY = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [1:0] END_CLEAN     = 2'd0;
    localparam logic [1:0] END_PARTIAL   = 2'd1;
    localparam logic [1:0] END_TRUNCATED = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_DATA_W = 168;

    // everything one input byte causes: an optional frame record and an optional summary
    typedef struct packed {
        logic        rec_valid;
        logic [1:0]  rec_kind;
        logic [7:0]  frame_type;
        logic        type_known;
        logic [23:0] payload_length;
        logic [7:0]  frame_flags;
        logic [30:0] stream_id;
        logic [31:0] goaway_last_stream;
        logic [31:0] goaway_error_code;
        logic        end_valid;
        logic [1:0]  end_status;
        logic [23:0] leftover_count;
    } h2fp_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } h2fp_qstat_t;

endpackage

`default_nettype wire

// ===== sv/h2fp_front.sv =====
// byte parser: tracks header and payload position and builds queue entries
`default_nettype none

module h2fp_front
    import h2fp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,
    input  wire h2fp_qstat_t qstat,
    output logic             push,
    output h2fp_entry_t      entry
);

    logic        in_payload_reg,   in_payload_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [23:0] length_reg,       length_next;
    logic [7:0]  type_reg,         type_next;
    logic [7:0]  flags_reg,        flags_next;
    logic [31:0] stream_reg,       stream_next;
    logic [23:0] payload_left_reg, payload_left_next;
    logic [3:0]  goaway_count_reg, goaway_count_next;
    logic [63:0] goaway_words_reg, goaway_words_next;
    logic        accept;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = accept && (entry.rec_valid || entry.end_valid);

    always_comb begin
        in_payload_next   = in_payload_reg;
        header_count_next = header_count_reg;
        length_next       = length_reg;
        type_next         = type_reg;
        flags_next        = flags_reg;
        stream_next       = stream_reg;
        payload_left_next = payload_left_reg;
        goaway_count_next = goaway_count_reg;
        goaway_words_next = goaway_words_reg;
        entry             = '0;

        if (!in_payload_reg) begin
            if (header_count_reg < HDR_TYPE_POS) begin
                length_next = {length_reg[15:0], s_tdata};
            end else if (header_count_reg == HDR_TYPE_POS) begin
                type_next = s_tdata;
            end else if (header_count_reg == HDR_FLAGS_POS) begin
                flags_next = s_tdata;
            end else begin
                stream_next = {stream_reg[23:0], s_tdata};
            end
            if (header_count_reg == HDR_LAST) begin
                entry.rec_valid      = 1'b1;
                entry.rec_kind       = KIND_HEADER;
                entry.frame_type     = type_reg;
                entry.type_known     = type_reg < KNOWN_TYPES;
                entry.payload_length = length_next;
                entry.frame_flags    = flags_reg;
                entry.stream_id      = stream_next[30:0];
                header_count_next    = '0;
                payload_left_next    = length_next;
                in_payload_next      = length_next != '0;
                goaway_count_next    = '0;
                goaway_words_next    = '0;
            end else begin
                header_count_next = header_count_reg + 4'd1;
            end
        end else begin
            // first eight goaway payload bytes carry last stream and error code
            if (type_reg == FRAME_TYPE_GOAWAY && length_reg >= GOAWAY_MIN_LEN &&
                goaway_count_reg < GOAWAY_BYTES) begin
                goaway_words_next = {goaway_words_reg[55:0], s_tdata};
                goaway_count_next = goaway_count_reg + 4'd1;
                if (goaway_count_reg == GOAWAY_LAST) begin
                    entry.rec_valid          = 1'b1;
                    entry.rec_kind           = KIND_GOAWAY;
                    entry.frame_type         = type_reg;
                    entry.type_known         = type_reg < KNOWN_TYPES;
                    entry.payload_length     = length_reg;
                    entry.frame_flags        = flags_reg;
                    entry.stream_id          = stream_reg[30:0];
                    entry.goaway_last_stream = goaway_words_next[63:32];
                    entry.goaway_error_code  = goaway_words_next[31:0];
                end
            end
            if (payload_left_reg != '0) begin
                payload_left_next = payload_left_reg - 24'd1;
            end
            if (payload_left_next == '0) begin
                in_payload_next = 1'b0;
            end
        end

        if (s_tlast) begin
            entry.end_valid = 1'b1;
            if (in_payload_next) begin
                entry.end_status     = END_TRUNCATED;
                entry.leftover_count = payload_left_next;
            end else if (header_count_next != '0) begin
                entry.end_status     = END_PARTIAL;
                entry.leftover_count = {20'd0, header_count_next};
            end else begin
                entry.end_status     = END_CLEAN;
            end
            in_payload_next   = 1'b0;
            header_count_next = '0;
            length_next       = '0;
            type_next         = '0;
            flags_next        = '0;
            stream_next       = '0;
            payload_left_next = '0;
            goaway_count_next = '0;
            goaway_words_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg   <= 1'b0;
            header_count_reg <= '0;
            length_reg       <= '0;
            type_reg         <= '0;
            flags_reg        <= '0;
            stream_reg       <= '0;
            payload_left_reg <= '0;
            goaway_count_reg <= '0;
            goaway_words_reg <= '0;
        end else if (accept) begin
            in_payload_reg   <= in_payload_next;
            header_count_reg <= header_count_next;
            length_reg       <= length_next;
            type_reg         <= type_next;
            flags_reg        <= flags_next;
            stream_reg       <= stream_next;
            payload_left_reg <= payload_left_next;
            goaway_count_reg <= goaway_count_next;
            goaway_words_reg <= goaway_words_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/h2fp_queue.sv =====
// short entry queue between the parser and the output stage
`default_nettype none

`include "http2_frame_header_parser_defines.svh"

module h2fp_queue
    import h2fp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire h2fp_entry_t push_entry,
    input  wire logic        pop,
    output h2fp_entry_t      head_entry,
    output h2fp_qstat_t      qstat
);

    h2fp_entry_t             entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]       count_reg,  count_next;

    assign head_entry  = entry_mem[rd_ptr_reg];
    assign qstat.full  = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign qstat.empty = count_reg == '0;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    `H2FP_ASSERT(a_count_bound, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
    `H2FP_ASSERT(a_no_pop_empty, pop |-> !qstat.empty, "pop from empty queue")
    `H2FP_ASSERT(a_push_grows, (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)), "push lost")

endmodule

`default_nettype wire

// ===== sv/h2fp_back.sv =====
// output stage: expands queue entries into result words behind an output register
`default_nettype none

module h2fp_back
    import h2fp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire h2fp_entry_t           head_entry,
    input  wire h2fp_qstat_t           qstat,
    output logic                       pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                 m_tuser,
    output logic                       m_tlast
);

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg,  m_tdata_next;
    logic [1:0]            m_tuser_reg,  m_tuser_next;
    logic                  m_tlast_reg,  m_tlast_next;
    logic                  phase_reg,    phase_next;
    logic                  load;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign load = !qstat.empty && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        phase_next    = phase_reg;
        pop           = 1'b0;
        if (load) begin
            m_tvalid_next = 1'b1;
            if (head_entry.rec_valid && !phase_reg) begin
                m_tuser_next = head_entry.rec_kind;
                m_tdata_next = {6'd0, 24'd0, 2'd0,
                                head_entry.goaway_error_code,
                                head_entry.goaway_last_stream,
                                head_entry.stream_id,
                                head_entry.frame_flags,
                                head_entry.payload_length,
                                head_entry.type_known,
                                head_entry.frame_type};
                m_tlast_next = !head_entry.end_valid;
                pop          = !head_entry.end_valid;
                phase_next   = head_entry.end_valid;
            end else begin
                m_tuser_next = KIND_END;
                m_tdata_next = {6'd0, head_entry.leftover_count, head_entry.end_status,
                                136'd0};
                m_tlast_next = 1'b1;
                pop          = 1'b1;
                phase_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/http2_frame_header_parser.sv =====
// top level of the http2 frame header parser
// usage:
//   s_ channel takes one stream byte per word: tdata is the byte, tlast marks the
//   final byte of a received buffer
//   m_ channel gives result words: tuser is the record kind (frame header, goaway
//   detail, end summary), tlast marks the last result word caused by one byte
//   a byte may cause no result (payload skipping), one, or two (a frame record
//   followed by the end summary)
// timing:
//   one byte per cycle sustained; s_tready only drops when the four-entry
//   queue between parser and output stage is full
//   a result word for an accepted byte is written into the queue, then loaded into the
//   output register that drives m_; a second word for the same byte follows it
// reset:
//   aresetn low clears the parser to expect a frame header and empties the queue
//   and the output register; an end summary also returns the parser to that state
// stall:
//   the output register holds its word while m_tready is low; the parser keeps
//   accepting bytes until the queue fills
`default_nettype none

module http2_frame_header_parser
    import h2fp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input byte channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] data_byte
    input  wire logic                  s_tlast,   // end_of_buffer
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [7:0] frame_type, [8] type_known, [32:9] payload_length, [40:33] frame_flags,
    // [71:41] stream_id, [103:72] goaway_last_stream, [135:104] goaway_error_code,
    // [137:136] end_status, [161:138] leftover_count, [167:162] zero
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic [1:0]                 m_tuser,   // [1:0] record_kind
    output logic                       m_tlast    // last_of_run
);

    // entry built by the parser for the byte being accepted
    h2fp_entry_t push_entry;
    // entry at the head of the queue, seen by the output stage
    h2fp_entry_t head_entry;
    h2fp_qstat_t qstat;
    logic        push;
    logic        pop;

    // front: byte accept and frame parsing
    h2fp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .qstat    (qstat),
        .push     (push),
        .entry    (push_entry)
    );

    // queue decoupling parser and output
    h2fp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    // back: one or two result words per entry
    h2fp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
